[rtl/core/cdq_pkg.sv]
// ============================================================================
// cdq_pkg
// Shared types and constants for the circular deque: operation codes, cell
// commands and default sizes.
// ============================================================================
`default_nettype none

package cdq_pkg;

    localparam int WORD_W        = 32;
    localparam int DEPTH_DEFAULT = 32;

    typedef enum logic [1:0] {
        KIND_PUSH_BACK  = 2'd0,
        KIND_POP_BACK   = 2'd1,
        KIND_PUSH_FRONT = 2'd2,
        KIND_POP_FRONT  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_POP_FRONT,
        OP_PUSH_BACK,
        OP_POP_BACK
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [WORD_W-1:0]   word;
    } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/core/cdq_cell.sv]
// ============================================================================
// cdq_cell
// One storage cell of the deque chain. Holds a word and an occupied flag and
// trades them with its neighbors on front pushes and pops; takes or drops the
// word locally when it sits at the back boundary.
// ============================================================================
`default_nettype none

module cdq_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire cdq_pkg::cell_cmd_t         cmd,
    input  wire logic                       prev_valid,
    input  wire logic [cdq_pkg::WORD_W-1:0] prev_data,
    input  wire logic                       next_valid,
    input  wire logic [cdq_pkg::WORD_W-1:0] next_data,
    output logic                            valid,
    output logic [cdq_pkg::WORD_W-1:0]      data,
    output logic [cdq_pkg::WORD_W-1:0]      back_tap
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [cdq_pkg::WORD_W-1:0] data_reg;
    logic [cdq_pkg::WORD_W-1:0] data_next;
    logic                       is_back;

    assign is_back = valid_reg && !next_valid;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (cmd.op)
            cdq_pkg::OP_PUSH_FRONT: begin
                valid_next = prev_valid;
                data_next  = prev_data;
            end
            cdq_pkg::OP_POP_FRONT: begin
                valid_next = next_valid;
                data_next  = next_data;
            end
            cdq_pkg::OP_PUSH_BACK: begin
                if (!valid_reg && prev_valid) begin
                    valid_next = 1'b1;
                    data_next  = cmd.word;
                end
            end
            cdq_pkg::OP_POP_BACK: begin
                if (is_back) begin
                    valid_next = 1'b0;
                end
            end
            default: begin
                valid_next = valid_reg;
                data_next  = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign valid    = valid_reg;
    assign data     = data_reg;
    assign back_tap = is_back ? data_reg : '0;

endmodule

`default_nettype wire

[rtl/core/circular_deque_unit.sv]
// ============================================================================
// circular_deque_unit
// Double-ended queue of signed 32-bit words held in a chain of cells, front
// at cell zero. Accepts push/pop at either end and reports the outcome.
// ----------------------------------------------------------------------------
// Results: registered on the master side in the cycle after the input transaction is accepted.
// Throughput: one operation per cycle while the master side is not stalled; each cell shifts or updates in one step.
// Reset: occupancy, cell occupied flags and the output valid clear; stored
//        words are not reset.
// ============================================================================
`default_nettype none

module circular_deque_unit #(
    parameter int DEPTH  = cdq_pkg::DEPTH_DEFAULT,
    parameter int CNT_W  = $clog2(DEPTH + 1),
    parameter int TDATA_W = ((cdq_pkg::WORD_W + CNT_W + 2 + 7) / 8) * 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [cdq_pkg::WORD_W-1:0] s_tdata,  // [31:0] value
    input  wire logic [1:0]                 s_tuser,  // [1:0] kind
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // m_tdata: result_value, occupancy, is_empty, is_full, zero pad
    output logic [TDATA_W-1:0]              m_tdata,
    output logic                            m_tuser   // [0] ok
);

    localparam int OUT_BITS = cdq_pkg::WORD_W + CNT_W + 2;

    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       out_valid_reg;
    logic                       out_ok_reg;
    logic [cdq_pkg::WORD_W-1:0] out_value_reg;
    logic [CNT_W-1:0]           out_count_reg;
    logic                       out_empty_reg;
    logic                       out_full_reg;

    logic                       accept;
    logic                       full;
    logic                       empty;
    logic                       op_ok;
    logic [cdq_pkg::WORD_W-1:0] pop_value;
    logic [cdq_pkg::WORD_W-1:0] back_value;
    cdq_pkg::kind_t             kind;
    cdq_pkg::cell_cmd_t         cmd;

    logic [DEPTH-1:0]           cell_valid;
    logic [cdq_pkg::WORD_W-1:0] cell_data [DEPTH];
    logic [cdq_pkg::WORD_W-1:0] cell_tap  [DEPTH];

    assign kind     = cdq_pkg::kind_t'(s_tuser);
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb begin
        op_ok     = 1'b0;
        cmd.op    = cdq_pkg::OP_HOLD;
        cmd.word  = s_tdata;
        count_next = count_reg;
        pop_value = '0;
        case (kind)
            cdq_pkg::KIND_PUSH_BACK: begin
                op_ok = !full;
                if (accept && op_ok) begin
                    cmd.op     = cdq_pkg::OP_PUSH_BACK;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            cdq_pkg::KIND_POP_BACK: begin
                op_ok = !empty;
                if (op_ok) begin
                    pop_value = back_value;
                end
                if (accept && op_ok) begin
                    cmd.op     = cdq_pkg::OP_POP_BACK;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            cdq_pkg::KIND_PUSH_FRONT: begin
                op_ok = !full;
                if (accept && op_ok) begin
                    cmd.op     = cdq_pkg::OP_PUSH_FRONT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            cdq_pkg::KIND_POP_FRONT: begin
                op_ok = !empty;
                if (op_ok) begin
                    pop_value = cell_data[0];
                end
                if (accept && op_ok) begin
                    cmd.op     = cdq_pkg::OP_POP_FRONT;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        back_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_value = back_value | cell_tap[i];
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                       prev_valid;
            logic [cdq_pkg::WORD_W-1:0] prev_data;
            logic                       next_valid;
            logic [cdq_pkg::WORD_W-1:0] next_data;

            if (g == 0) begin : g_first
                assign prev_valid = 1'b1;
                assign prev_data  = s_tdata;
            end else begin : g_mid_prev
                assign prev_valid = cell_valid[g-1];
                assign prev_data  = cell_data[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign next_valid = 1'b0;
                assign next_data  = '0;
            end else begin : g_mid_next
                assign next_valid = cell_valid[g+1];
                assign next_data  = cell_data[g+1];
            end

            cdq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .prev_valid (prev_valid),
                .prev_data  (prev_data),
                .next_valid (next_valid),
                .next_data  (next_data),
                .valid      (cell_valid[g]),
                .data       (cell_data[g]),
                .back_tap   (cell_tap[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_ok_reg    <= op_ok;
            out_value_reg <= pop_value;
            out_count_reg <= count_next;
            out_empty_reg <= (count_next == '0);
            out_full_reg  <= (count_next == CNT_W'(DEPTH));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = TDATA_W'({out_full_reg, out_empty_reg, out_count_reg, out_value_reg});

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_chain_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == int'(count_reg))
        else $error("occupied cells disagree with occupancy");

    a_refused_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !op_ok |=> $stable(count_reg) && $stable(cell_valid))
        else $error("refused operation changed state");

    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ok_reg |-> out_value_reg == '0)
        else $error("refused operation returned data");

    a_out_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_empty_reg == (out_count_reg == '0)) && (OUT_BITS <= TDATA_W))
        else $error("empty flag disagrees with occupancy");

endmodule

`default_nettype wire

[dv/cdq_checker.sv]
// ============================================================================
// cdq_checker
// Watches both stream channels of circular_deque_unit, keeps a shadow deque
// of the block, predicts the outcome of every accepted operation, and checks
// each returned result field by field against the oldest outstanding
// outcome.
// ============================================================================

module cdq_checker #(
    parameter int DEPTH   = cdq_pkg::DEPTH_DEFAULT,
    parameter int CNT_W   = $clog2(DEPTH + 1),
    parameter int TDATA_W = ((cdq_pkg::WORD_W + CNT_W + 2 + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [cdq_pkg::WORD_W-1:0] s_tdata,  // [31:0] value
    input  logic [1:0]                 s_tuser,  // [1:0] kind
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    // m_tdata: result_value, occupancy, is_empty, is_full, zero pad
    input  logic [TDATA_W-1:0]         m_tdata,
    input  logic                       m_tuser,  // [0] ok
    output int                         n_fail,
    output int                         n_pending,
    output int                         n_checked,
    output int                         n_refused,
    output int                         n_full_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] word;
        logic [CNT_W-1:0]         occupancy;
        logic                     is_empty;
        logic                     is_full;
    } deque_outcome_t;

    logic [WORD_W-1:0] shadow_words [DEPTH];
    int                shadow_head;
    int                shadow_fill;
    deque_outcome_t    pending_outcomes [$];

    initial begin
        n_fail      = 0;
        n_pending   = 0;
        n_checked   = 0;
        n_refused   = 0;
        n_full_seen = 0;
        shadow_head = 0;
        shadow_fill = 0;
    end

    function automatic deque_outcome_t apply_deque_op(kind_t kind, logic [WORD_W-1:0] word);
        deque_outcome_t r;
        int             pos;
        r = '0;
        case (kind)
            KIND_PUSH_BACK: begin
                if (shadow_fill < DEPTH) begin
                    pos = (shadow_head + shadow_fill) % DEPTH;
                    shadow_words[pos] = word;
                    shadow_fill++;
                    r.ok = 1'b1;
                end
            end
            KIND_POP_BACK: begin
                if (shadow_fill > 0) begin
                    pos = (shadow_head + shadow_fill - 1) % DEPTH;
                    r.word = shadow_words[pos];
                    shadow_fill--;
                    r.ok = 1'b1;
                end
            end
            KIND_PUSH_FRONT: begin
                if (shadow_fill < DEPTH) begin
                    shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
                    shadow_words[shadow_head] = word;
                    shadow_fill++;
                    r.ok = 1'b1;
                end
            end
            default: begin
                if (shadow_fill > 0) begin
                    r.word = shadow_words[shadow_head];
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_fill--;
                    r.ok = 1'b1;
                end
            end
        endcase
        r.occupancy = CNT_W'(shadow_fill);
        r.is_empty  = (shadow_fill == 0);
        r.is_full   = (shadow_fill == DEPTH);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint want, longint seen);
        if (n_fail < 100)
            $display("%0t mismatch on %s: expected %0h, got %0h", $time, field, want, seen);
        n_fail++;
    endtask

    always @(posedge aclk) begin
        deque_outcome_t want;
        deque_outcome_t seen;
        if (!aresetn) begin
            shadow_head = 0;
            shadow_fill = 0;
            pending_outcomes.delete();
        end else begin
            if (s_tvalid && s_tready)
                pending_outcomes.push_back(apply_deque_op(kind_t'(s_tuser), s_tdata));
            if (m_tvalid && m_tready) begin
                seen.ok        = m_tuser;
                seen.word      = m_tdata[WORD_W-1:0];
                seen.occupancy = m_tdata[WORD_W +: CNT_W];
                seen.is_empty  = m_tdata[WORD_W + CNT_W];
                seen.is_full   = m_tdata[WORD_W + CNT_W + 1];
                if (pending_outcomes.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, seen);
                end else begin
                    want = pending_outcomes.pop_front();
                    n_checked++;
                    if (!want.ok)
                        n_refused++;
                    if (want.is_full)
                        n_full_seen++;
                    if (seen.ok !== want.ok)
                        report_mismatch("ok", want.ok, seen.ok);
                    if (seen.word !== want.word)
                        report_mismatch("result_value", want.word, seen.word);
                    if (seen.occupancy !== want.occupancy)
                        report_mismatch("occupancy", want.occupancy, seen.occupancy);
                    if (seen.is_empty !== want.is_empty)
                        report_mismatch("is_empty", want.is_empty, seen.is_empty);
                    if (seen.is_full !== want.is_full)
                        report_mismatch("is_full", want.is_full, seen.is_full);
                end
            end
        end
        n_pending <= pending_outcomes.size();
    end

endmodule

[dv/tb_circular_deque_unit.sv]
// ============================================================================
// tb_circular_deque_unit
// Drives push and pop operations at both ends of circular_deque_unit: a
// directed opening on empty, wrap and extreme-value cases, then random
// fill, drain and mixed traffic with bursty stalls on both channels.
// ============================================================================

module tb_circular_deque_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int TDATA_W    = ((WORD_W + CNT_W + 2 + 7) / 8) * 8;
    localparam int N_ITEMS    = 1550;
    localparam int TAIL_ITEMS = 150;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } traffic_mode_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [WORD_W-1:0]  s_tdata;   // [31:0] value
    logic [1:0]         s_tuser;   // [1:0] kind
    logic               m_tvalid;
    logic               m_tready;
    // m_tdata: result_value, occupancy, is_empty, is_full, zero pad
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;   // [0] ok

    int n_fail;
    int n_pending;
    int n_checked;
    int n_refused;
    int n_full_seen;
    int n_sent;
    bit tail_phase;
    bit calm;

    circular_deque_unit #(.DEPTH(DEPTH)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cdq_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .n_fail      (n_fail),
        .n_pending   (n_pending),
        .n_checked   (n_checked),
        .n_refused   (n_refused),
        .n_full_seen (n_full_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic send_op(kind_t kind, logic [WORD_W-1:0] word);
        if (!tail_phase && !calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic kind_t pick_kind(traffic_mode_t mode);
        bit push;
        case (mode)
            MODE_FILL:  push = ($urandom_range(0, 99) < 85);
            MODE_DRAIN: push = ($urandom_range(0, 99) < 15);
            default:    push = $urandom_range(0, 1);
        endcase
        if (push)
            return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
    endfunction

    // receiver: ready bursts with stall bursts between them
    initial begin
        m_tready <= 1'b0;
        forever begin
            if (!tail_phase && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    initial begin
        traffic_mode_t mode;
        int            run_len;
        n_sent     = 0;
        tail_phase = 1'b0;
        calm       = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= KIND_PUSH_BACK;
        s_tdata  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_op(KIND_POP_BACK, 32'h1234_5678);
        send_op(KIND_POP_FRONT, 32'hffff_ffff);
        send_op(KIND_PUSH_FRONT, 32'h7fff_ffff);
        send_op(KIND_PUSH_FRONT, 32'h8000_0000);
        send_op(KIND_PUSH_BACK, 32'hffff_ffff);
        send_op(KIND_PUSH_BACK, 32'h0000_0000);
        send_op(KIND_POP_FRONT, '0);
        send_op(KIND_POP_BACK, '0);
        send_op(KIND_POP_BACK, '0);
        send_op(KIND_POP_FRONT, '0);
        send_op(KIND_POP_FRONT, '0);
        send_op(KIND_PUSH_BACK, 32'h5555_5555);
        send_op(KIND_PUSH_FRONT, 32'haaaa_aaaa);
        send_op(KIND_POP_BACK, '0);
        send_op(KIND_POP_BACK, '0);
        send_op(KIND_POP_BACK, '0);

        while (n_sent < N_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       mode = MODE_FILL;
                1:       mode = MODE_DRAIN;
                default: mode = MODE_MIX;
            endcase
            calm    = ($urandom_range(0, 3) == 0);
            run_len = $urandom_range(20, 60);
            repeat (run_len) begin
                if (n_sent < N_ITEMS) begin
                    tail_phase = (n_sent >= N_ITEMS - TAIL_ITEMS);
                    send_op(pick_kind(mode), pick_word());
                end
            end
        end
        s_tvalid <= 1'b0;

        while (n_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("summary: %0d operations sent, %0d results checked", n_sent, n_checked);
        $display("summary: %0d refused, %0d results with the deque full", n_refused,
                 n_full_seen);
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
